>>> rtl/srp_pkg.sv
// Shared types, constants and helper functions for the stick rect-to-polar block.
`timescale 1ns / 1ps

package srp_pkg;

    // Angle accumulator width, in bits of one full turn
    localparam int DATA_WIDTH   = 16;
    // Number of CORDIC micro-rotations, capped at the table depth
    localparam int CORDIC_STEPS = 16;
    localparam int NSTEPS       = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;
    localparam int STEP_W       = $clog2(NSTEPS);

    // Fixed-point working formats
    localparam int GUARD_BITS   = 8;
    localparam int WORK_W       = 16 + 1 + GUARD_BITS + 2;
    localparam int PROD_W       = WORK_W - 1 + 32;
    localparam int SUM_W        = PROD_W + 1;
    localparam int MAG_SH       = 32 + GUARD_BITS;

    // Cycles from accepted item to done strobe
    localparam int LATENCY      = NSTEPS + 3;

    localparam logic [31:0]         INV_GAIN_Q32 = 32'd2608131496;
    localparam logic [SUM_W-1:0]    MAG_ROUND    = SUM_W'(1) << (MAG_SH - 1);
    localparam logic [14:0]         MAG_MAX      = 15'h7FFF;
    localparam logic [DATA_WIDTH-1:0] HALF_TURN  = DATA_WIDTH'(1) << (DATA_WIDTH - 1);

    // Output angle codes for the axis cases
    localparam logic [15:0] ANGLE_DOWN  = 16'd0;
    localparam logic [15:0] ANGLE_RIGHT = 16'd16384;
    localparam logic [15:0] ANGLE_UP    = 16'd32768;
    localparam logic [15:0] ANGLE_LEFT  = 16'd49152;

    // atan(2^-i) / (2*pi) * 2^32, truncated
    localparam logic [31:0] ATAN_TURN32 [32] = '{
        32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2E, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
        32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
        32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051,
        32'h00000028, 32'h00000014, 32'h0000000A, 32'h00000005,
        32'h00000002, 32'h00000001, 32'h00000000, 32'h00000000
    };

    localparam int          ATAN_SH   = 32 - DATA_WIDTH;
    localparam logic [32:0] ATAN_HALF = (ATAN_SH > 0) ? (33'd1 << (ATAN_SH - 1)) : 33'd0;

    // Angle output rescale: DATA_WIDTH bits of a turn down/up to 16 bits
    localparam int ANG_SH_DN = (DATA_WIDTH > 16) ? DATA_WIDTH - 16 : 0;
    localparam int ANG_SH_UP = (DATA_WIDTH < 16) ? 16 - DATA_WIDTH : 0;
    localparam logic [DATA_WIDTH:0] ANG_HALF =
        (DATA_WIDTH > 16) ? ((DATA_WIDTH + 1)'(1) << (ANG_SH_DN - 1)) : '0;

    typedef struct packed {
        logic signed [15:0] axis_x;
        logic signed [15:0] axis_y;
    } in_t;

    typedef struct packed {
        logic [15:0] angle;
        logic [14:0] magnitude;
    } out_t;

    // What moves from one cell to the next
    typedef struct packed {
        logic                      valid;
        logic                      special;
        out_t                      spec_res;
        logic signed [WORK_W-1:0]  u;
        logic signed [WORK_W-1:0]  v;
        logic [DATA_WIDTH-1:0]     acc;
    } cell_t;

    // Table entry rounded half up to DATA_WIDTH bits
    function automatic logic [DATA_WIDTH-1:0] atan_entry(input logic [4:0] idx);
        logic [32:0] t;
        t = {1'b0, ATAN_TURN32[idx]} + ATAN_HALF;
        return DATA_WIDTH'(t >> ATAN_SH);
    endfunction

    // |x| saturated to just below 1.0
    function automatic logic [14:0] sat_mag(input logic signed [16:0] x);
        logic [16:0] a;
        a = x[16] ? 17'(-x) : 17'(x);
        return (a > 17'(MAG_MAX)) ? MAG_MAX : a[14:0];
    endfunction

    // Accumulator modulo one turn, rounded half up to 16 bits
    function automatic logic [15:0] turn_to_16(input logic [DATA_WIDTH-1:0] acc);
        logic [DATA_WIDTH:0] r;
        r = {1'b0, acc} + ANG_HALF;
        return 16'(32'(r[DATA_WIDTH-1:0] >> ANG_SH_DN) << ANG_SH_UP);
    endfunction

endpackage

>>> rtl/srp_prep.sv
// Input stage: mirror, axis special cases, half-plane fold and guard-bit scaling.
`timescale 1ns / 1ps

module srp_prep (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          take,
    input  logic          mirror,
    input  srp_pkg::in_t  sample,
    output srp_pkg::cell_t dout
);
    import srp_pkg::*;

    logic signed [16:0] rx;
    logic signed [16:0] u17;
    logic signed [16:0] v17;
    logic signed [16:0] un;
    logic signed [16:0] vn;
    logic               neg;
    cell_t              data_next;
    cell_t              data_reg;
    logic               valid_reg;

    // Working pair: u = axis_y, v = +/-axis_x by mirror; both negated when u < 0
    always_comb
    begin
        rx  = 17'(sample.axis_x);
        u17 = 17'(sample.axis_y);
        v17 = mirror ? -rx : rx;
        neg = u17[16];
        un  = neg ? -u17 : u17;
        vn  = neg ? -v17 : v17;
    end

    // Scale and set fold offset; axis cases carry a ready result down the chain
    always_comb
    begin
        data_next          = '0;
        data_next.valid    = take;
        data_next.u        = WORK_W'(un) <<< GUARD_BITS;
        data_next.v        = WORK_W'(vn) <<< GUARD_BITS;
        data_next.acc      = neg ? HALF_TURN : '0;
        if (u17 == '0 && v17 == '0)
        begin
            data_next.special            = 1'b1;
            data_next.spec_res.angle     = ANGLE_DOWN;
            data_next.spec_res.magnitude = '0;
        end
        else if (v17 == '0)
        begin
            data_next.special            = 1'b1;
            data_next.spec_res.angle     = u17[16] ? ANGLE_UP : ANGLE_DOWN;
            data_next.spec_res.magnitude = sat_mag(u17);
        end
        else if (u17 == '0)
        begin
            data_next.special            = 1'b1;
            data_next.spec_res.angle     = v17[16] ? ANGLE_LEFT : ANGLE_RIGHT;
            data_next.spec_res.magnitude = sat_mag(v17);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= take;
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    always_comb
    begin
        dout       = data_reg;
        dout.valid = valid_reg;
    end

endmodule

>>> rtl/srp_cell.sv
// One CORDIC vectoring cell: a single micro-rotation, registered.
`timescale 1ns / 1ps

module srp_cell (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [srp_pkg::STEP_W-1:0]      shift,
    input  logic [srp_pkg::DATA_WIDTH-1:0]  atan,
    input  srp_pkg::cell_t                  din,
    output srp_pkg::cell_t                  dout
);
    import srp_pkg::*;

    logic signed [WORK_W-1:0] du;
    logic signed [WORK_W-1:0] dv;
    cell_t                    data_next;
    cell_t                    data_reg;
    logic                     valid_reg;

    // Rotate toward v = 0; arithmetic shift floors negatives
    always_comb
    begin
        du        = din.v >>> shift;
        dv        = din.u >>> shift;
        data_next = din;
        if (!din.v[WORK_W-1])
        begin
            data_next.u   = din.u + du;
            data_next.v   = din.v - dv;
            data_next.acc = din.acc + atan;
        end
        else
        begin
            data_next.u   = din.u - du;
            data_next.v   = din.v + dv;
            data_next.acc = din.acc - atan;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= din.valid;
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    always_comb
    begin
        dout       = data_reg;
        dout.valid = valid_reg;
    end

endmodule

>>> rtl/srp_out.sv
// Output stages: gain correction multiply, rounding, saturation, result register.
`timescale 1ns / 1ps

module srp_out (
    input  logic           clk,
    input  logic           rst_n,
    input  srp_pkg::cell_t din,
    output srp_pkg::out_t  result,
    output logic           done
);
    import srp_pkg::*;

    logic [WORK_W-2:0] u_clamp;
    logic [PROD_W-1:0] prod_next;
    logic [PROD_W-1:0] prod_reg;
    logic              a_valid_reg;
    logic              a_special_reg;
    out_t              a_spec_reg;
    logic [15:0]       a_angle_reg;
    logic [SUM_W-1:0]  sum;
    logic [14:0]       mag;
    out_t              result_next;
    out_t              result_reg;
    logic              done_reg;

    // Stage A: length, clamped at zero, times inverse gain; angle to 16 bits
    always_comb
    begin
        u_clamp   = din.u[WORK_W-1] ? '0 : din.u[WORK_W-2:0];
        prod_next = PROD_W'(u_clamp) * PROD_W'(INV_GAIN_Q32);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            a_valid_reg <= din.valid;
            done_reg    <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg      <= prod_next;
        a_special_reg <= din.special;
        a_spec_reg    <= din.spec_res;
        a_angle_reg   <= turn_to_16(din.acc);
    end

    // Stage B: round, saturate, pick axis result
    always_comb
    begin
        sum = {1'b0, prod_reg} + MAG_ROUND;
        if (|sum[SUM_W-1:MAG_SH+15])
            mag = MAG_MAX;
        else
            mag = sum[MAG_SH+14:MAG_SH];
        if (a_special_reg)
            result_next = a_spec_reg;
        else
        begin
            result_next.angle     = a_angle_reg;
            result_next.magnitude = mag;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign result = result_reg;
    assign done   = done_reg;

endmodule

>>> rtl/stick_rect_to_polar.sv
// Top level: stick sample to polar angle and magnitude, pipelined CORDIC.
`timescale 1ns / 1ps

// Takes one item per clock cycle, every cycle: busy never rises. Each item's
// result is on result with done high for one cycle, and passes through one
// input stage, one CORDIC cell per step in a row, a multiply stage and an
// output register. Results leave in order and cannot be held off by the
// receiver. mirror_x is written through cfg_valid/cfg_data, always ready,
// and should change only while no items are in flight.
module stick_rect_to_polar (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  srp_pkg::in_t  sample,
    output srp_pkg::out_t result,
    output logic          done,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic          cfg_data
);
    import srp_pkg::*;

    logic  mirror_reg;
    logic  take;
    cell_t chain [NSTEPS+1];

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign take      = start && !busy;

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mirror_reg <= 1'b0;
        else if (cfg_valid && cfg_ready)
            mirror_reg <= cfg_data;
    end

    srp_prep u_prep (
        .clk    (clk),
        .rst_n  (rst_n),
        .take   (take),
        .mirror (mirror_reg),
        .sample (sample),
        .dout   (chain[0])
    );

    // Row of rotation cells
    for (genvar i = 0; i < NSTEPS; i++)
    begin : g_cell
        srp_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .shift (STEP_W'(i)),
            .atan  (atan_entry(5'(i))),
            .din   (chain[i]),
            .dout  (chain[i+1])
        );
    end

    srp_out u_out (
        .clk    (clk),
        .rst_n  (rst_n),
        .din    (chain[NSTEPS]),
        .result (result),
        .done   (done)
    );

endmodule

>>> rtl/srp_checker.sv
// Port-level checker for stick_rect_to_polar and its bind.
`timescale 1ns / 1ps

module srp_checker (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic          busy,
    input  srp_pkg::in_t  sample,
    input  srp_pkg::out_t result,
    input  logic          done,
    input  logic          cfg_valid,
    input  logic          cfg_ready,
    input  logic          cfg_data
);
    import srp_pkg::*;

    localparam int CNT_W = $clog2(LATENCY + 1);

    logic [CNT_W-1:0] since_rst_reg;
    logic             warm;

    // Cycles since reset release, saturating
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            since_rst_reg <= '0;
        else if (since_rst_reg != CNT_W'(LATENCY))
            since_rst_reg <= since_rst_reg + 1'b1;
    end

    assign warm = (since_rst_reg == CNT_W'(LATENCY));

    // Every accepted item gives exactly one done, a fixed latency later
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        warm |-> (done == $past(start && !busy, LATENCY)))
        else $error("done does not match accepted item latency");

    // Origin gives zero angle and zero magnitude
    a_origin: assert property (@(posedge clk) disable iff (!rst_n)
        (warm && $past(start && !busy && sample.axis_x == 16'sd0
                       && sample.axis_y == 16'sd0, LATENCY))
        |-> (result.angle == 16'd0 && result.magnitude == 15'd0))
        else $error("origin result not zero");

    // Straight down: angle 0, magnitude equals the Y sample
    a_down: assert property (@(posedge clk) disable iff (!rst_n)
        (warm && $past(start && !busy && sample.axis_x == 16'sd0
                       && sample.axis_y > 16'sd0, LATENCY))
        |-> (result.angle == 16'd0
             && result.magnitude == $past(sample.axis_y[14:0], LATENCY)))
        else $error("down-axis result wrong");

    // Config writes are never held off
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("config write stalled");

endmodule

bind stick_rect_to_polar srp_checker u_srp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .sample    (sample),
    .result    (result),
    .done      (done),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
);
